// ===== rtl/core/mma_pkg.sv =====
package mma_pkg;

  // Fixed field widths
  localparam int CHAN_IN_W = 3;
  localparam int SAMPLE_W  = 16;
  localparam int AVG_W     = 16;
  localparam int COUNT_W   = 5;

  // Sizing
  localparam int CHANNELS     = 8;
  localparam int WINDOW_DEPTH = 16;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WP_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + ((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0) + 1;
  localparam int IT_W  = $clog2(SUM_W);

  typedef logic [CH_W-1:0]            ch_t;
  typedef logic [WP_W-1:0]            wp_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [CNT_W:0]             rem_ext_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [SUM_W-1:0]           mag_t;
  typedef logic [IT_W-1:0]            it_t;
  typedef logic [AVG_W-1:0]           avg_t;
  typedef logic [COUNT_W-1:0]         count_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_PREP   = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

endpackage

// ===== rtl/core/multichannel_moving_average.sv =====
// Sequence: an accepted transaction passes read, update, prepare, a 21-bit divide and
//   finish before its result shows at the output.
// Flow: one transaction at a time; in_stall is high while one is in work. The restoring
//   divider computes one quotient bit per cycle. A stalled result still held in the
//   output register holds the finish step.
// Reset (rst, synchronous, active high) clears pointers, fill counts, running sums,
//   the sequencer and the output valid. The sample memory is not cleared.
module multichannel_moving_average (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mma_pkg::CHAN_IN_W-1:0]      channel,
  input  logic signed [mma_pkg::SAMPLE_W-1:0] sample,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mma_pkg::AVG_W-1:0]   average,
  output logic [mma_pkg::COUNT_W-1:0]        valid_count
);

  mma_pkg::state_t state;

  // Per-channel control state: small, read at one place chosen by the latched channel
  mma_pkg::wp_t  write_pointer [mma_pkg::CHANNELS];
  mma_pkg::cnt_t fill_count    [mma_pkg::CHANNELS];
  mma_pkg::sum_t running_sum   [mma_pkg::CHANNELS];

  // Sample windows; never cleared, an old sample only enters the sum once the window is full
  mma_pkg::sample_t sample_store [mma_pkg::CHANNELS][mma_pkg::WINDOW_DEPTH];

  // Working registers of the transaction in flight
  mma_pkg::ch_t     ch;
  mma_pkg::sample_t sample_r;
  mma_pkg::sample_t old_sample;
  mma_pkg::sum_t    sum_r;
  logic             neg;

  // Divider: quotient shifts left through quo, remainder in rem
  mma_pkg::mag_t quo;
  mma_pkg::cnt_t rem;
  mma_pkg::cnt_t divisor;
  mma_pkg::it_t  it_cnt;

  logic               in_accept;
  logic               out_take;
  mma_pkg::ch_t       ch_in;
  logic               full;
  mma_pkg::cnt_t      cnt_next;
  mma_pkg::wp_t       wp_next;
  mma_pkg::sum_t      sum_next;
  mma_pkg::rem_ext_t  rem_sh;
  mma_pkg::rem_ext_t  diff;
  logic               ge;
  mma_pkg::avg_t      q16;

  assign in_stall  = (state != mma_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Channel numbers at or past CHANNELS wrap around; eight compare-subtract steps on 4 bits
  always_comb begin
    logic [mma_pkg::CHAN_IN_W:0] c;
    c = {1'b0, channel};
    for (int i = 0; i < 8; i++) begin
      if (c >= (mma_pkg::CHAN_IN_W + 1)'(mma_pkg::CHANNELS)) begin
        c = c - (mma_pkg::CHAN_IN_W + 1)'(mma_pkg::CHANNELS);
      end
    end
    ch_in = mma_pkg::ch_t'(c);
  end

  // Window bookkeeping for the update step
  assign full     = (fill_count[ch] == mma_pkg::cnt_t'(mma_pkg::WINDOW_DEPTH));
  assign cnt_next = full ? fill_count[ch] : fill_count[ch] + mma_pkg::cnt_t'(1);
  assign wp_next  = (write_pointer[ch] == mma_pkg::wp_t'(mma_pkg::WINDOW_DEPTH - 1)) ?
                    '0 : write_pointer[ch] + mma_pkg::wp_t'(1);
  assign sum_next = running_sum[ch] + mma_pkg::sum_t'(sample_r)
                    - (full ? mma_pkg::sum_t'(old_sample) : '0);

  // One restoring step
  assign rem_sh = {rem, quo[mma_pkg::SUM_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign ge     = !diff[mma_pkg::CNT_W];

  assign q16 = quo[mma_pkg::AVG_W-1:0];

  // Memory: old slot read and new sample written in the same cycle
  always_ff @(posedge clk) begin
    if (state == mma_pkg::S_READ) begin
      old_sample <= sample_store[ch][write_pointer[ch]];
      sample_store[ch][write_pointer[ch]] <= sample_r;
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mma_pkg::S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < mma_pkg::CHANNELS; i++) begin
        write_pointer[i] <= '0;
        fill_count[i]    <= '0;
        running_sum[i]   <= '0;
      end
    end else begin
      // the finish step reloads the register itself when it hands over a result
      if (out_take && state != mma_pkg::S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        mma_pkg::S_IDLE: begin
          if (in_accept) begin
            state <= mma_pkg::S_READ;
          end
        end
        mma_pkg::S_READ: begin
          state <= mma_pkg::S_UPDATE;
        end
        mma_pkg::S_UPDATE: begin
          running_sum[ch]   <= sum_next;
          fill_count[ch]    <= cnt_next;
          write_pointer[ch] <= wp_next;
          state             <= mma_pkg::S_PREP;
        end
        mma_pkg::S_PREP: begin
          state <= mma_pkg::S_DIV;
        end
        mma_pkg::S_DIV: begin
          if (it_cnt == '0) begin
            state <= mma_pkg::S_FINISH;
          end
        end
        mma_pkg::S_FINISH: begin
          // wait for a free output register
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= mma_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mma_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state)
      mma_pkg::S_IDLE: begin
        if (in_accept) begin
          ch       <= ch_in;
          sample_r <= sample;
        end
      end
      mma_pkg::S_UPDATE: begin
        sum_r   <= sum_next;
        divisor <= cnt_next;
      end
      mma_pkg::S_PREP: begin
        // divide magnitudes; sign comes back at the end (truncation toward zero)
        neg    <= sum_r[mma_pkg::SUM_W-1];
        quo    <= sum_r[mma_pkg::SUM_W-1] ? mma_pkg::mag_t'(-sum_r) : mma_pkg::mag_t'(sum_r);
        rem    <= '0;
        it_cnt <= mma_pkg::it_t'(mma_pkg::SUM_W - 1);
      end
      mma_pkg::S_DIV: begin
        rem    <= ge ? diff[mma_pkg::CNT_W-1:0] : rem_sh[mma_pkg::CNT_W-1:0];
        quo    <= {quo[mma_pkg::SUM_W-2:0], ge};
        it_cnt <= it_cnt - mma_pkg::it_t'(1);
      end
      mma_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          average     <= neg ? -q16 : q16;
          valid_count <= mma_pkg::count_t'(divisor);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/mma_checker.sv =====
module mma_assertions (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [mma_pkg::CHAN_IN_W-1:0]       channel,
  input logic signed [mma_pkg::SAMPLE_W-1:0] sample,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [mma_pkg::AVG_W-1:0]    average,
  input logic [mma_pkg::COUNT_W-1:0]         valid_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average) && $stable(valid_count))
    else $error("stalled result changed");

  // busy right after taking a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a result never appears the cycle after a transaction is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // a new result only comes from a transaction in work
  a_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

endmodule

bind multichannel_moving_average mma_assertions u_mma_assertions (.*);
